// ----- src/pwd_pkg.sv -----
// pwd_pkg: shared widths, status codes, register addresses and payload types
// for the polyline walk-to-distance block. No dependencies.
package pwd_pkg;

    localparam int COORD_BITS = 24;
    localparam int INDEX_BITS = 16;
    localparam int TGT_W      = 24;
    localparam int CAP_W      = 16;

    // segment length and square-root digit count
    localparam int LEN_W   = COORD_BITS + 1;
    localparam int SQ_W    = 2 * LEN_W;
    localparam int FRAC_W  = 16;
    localparam int Q_W     = FRAC_W + 1;
    localparam int MUL_A_W = LEN_W;
    localparam int MUL_B_W = (LEN_W > Q_W) ? LEN_W : Q_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int CNT_W   = 5;

    localparam logic [1:0] ST_PASS    = 2'd0;
    localparam logic [1:0] ST_TARGET  = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic ADDR_TARGET   = 1'b0;
    localparam logic ADDR_CAPACITY = 1'b1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic                         last_vertex;
    } vertex_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic [INDEX_BITS-1:0]        point_index;
        logic [1:0]                   status;
    } point_t;

    typedef struct packed {
        logic [TGT_W-1:0] target_distance;
        logic [CAP_W-1:0] out_capacity;
    } cfg_t;

endpackage

// ----- src/pwd_cfg.sv -----
// pwd_cfg: apb-style configuration registers (target distance, capacity)
// depends on pwd_pkg
module pwd_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output pwd_pkg::cfg_t      cfg
);

    logic [pwd_pkg::TGT_W-1:0] target_reg;
    logic [pwd_pkg::CAP_W-1:0] capacity_reg;
    logic                      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            capacity_reg <= '1;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                pwd_pkg::ADDR_TARGET:   target_reg   <= pwdata[pwd_pkg::TGT_W-1:0];
                pwd_pkg::ADDR_CAPACITY: capacity_reg <= pwdata[pwd_pkg::CAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            pwd_pkg::ADDR_TARGET:   prdata = {{(32-pwd_pkg::TGT_W){1'b0}}, target_reg};
            pwd_pkg::ADDR_CAPACITY: prdata = {{(32-pwd_pkg::CAP_W){1'b0}}, capacity_reg};
            default:                prdata = '0;
        endcase
    end

    assign cfg.target_distance = target_reg;
    assign cfg.out_capacity    = capacity_reg;

endmodule

// ----- src/pwd_mul.sv -----
// pwd_mul: shared unsigned multiplier with registered product, used for the
// squares of the deltas and for the scaled offsets. depends on pwd_pkg
module pwd_mul (
    input  logic                          clk,
    input  logic [pwd_pkg::MUL_A_W-1:0]   a,
    input  logic [pwd_pkg::MUL_B_W-1:0]   b,
    output logic [pwd_pkg::MUL_P_W-1:0]   p
);

    logic [pwd_pkg::MUL_P_W-1:0] p_reg;
    logic [pwd_pkg::MUL_P_W-1:0] p_next;

    assign p_next = {{pwd_pkg::MUL_B_W{1'b0}}, a} * {{pwd_pkg::MUL_A_W{1'b0}}, b};

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// ----- src/polyline_walk_to_distance_unit.sv -----
// polyline_walk_to_distance_unit: top level, vertex sequencer with square root,
// division and shared multiplier. depends on pwd_pkg, pwd_cfg, pwd_mul
//
// Vertices arrive one per transaction; the unit keeps the previous vertex and
// the distance walked. A vertex that opens a path, or that arrives after the
// target point or while the capacity is one or less, is taken and the unit is
// ready again in the next cycle; if it closes a path with the invalid status,
// the unit goes on to load the output register. Any other vertex, when it is
// passed, goes from the accepting cycle through two multiplier passes for the
// squares, one add, the square-root loop at one root bit per cycle, one
// compare and the load of the output. A vertex that reaches the target goes
// on from the compare to restoring division for the 16-bit fraction, two
// multiplier passes and forming the point before that load. The unit takes no
// new vertex until the current one is finished; a result waits in an output
// register, and a second result stalls the unit until the first is taken.
module polyline_walk_to_distance_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pwd_pkg::vertex_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pwd_pkg::point_t   out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CW = pwd_pkg::COORD_BITS;
    localparam int LW = pwd_pkg::LEN_W;
    localparam int SW = pwd_pkg::SQ_W;
    localparam int TW = pwd_pkg::TGT_W;
    localparam int IW = pwd_pkg::INDEX_BITS;
    localparam int QW = pwd_pkg::Q_W;
    localparam int FW = pwd_pkg::FRAC_W;
    localparam int NW = pwd_pkg::CNT_W;
    localparam int PW = pwd_pkg::MUL_P_W;
    localparam int BW = pwd_pkg::MUL_B_W;
    localparam int HW = (LW > TW) ? LW + 1 : TW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SQX, S_SQY, S_ADD, S_ROOT, S_CMP, S_DIV, S_MX, S_MY, S_FIN, S_OUT
    } state_t;

    pwd_pkg::cfg_t cfg;

    state_t                state_reg;
    logic signed [CW-1:0]  prev_x_reg, prev_y_reg;
    logic signed [CW-1:0]  x_reg, y_reg;
    logic                  last_reg;
    logic [TW-1:0]         walked_reg;
    logic [IW-1:0]         count_reg;
    logic                  found_reg;
    logic [LW-1:0]         ax_reg, ay_reg;
    logic                  negx_reg, negy_reg;
    logic [SW-1:0]         sq_reg;
    logic [LW+2:0]         rrem_reg;
    logic [LW-1:0]         root_reg;
    logic [NW-1:0]         cnt_reg;
    logic [LW:0]           divr_reg;
    logic [QW-1:0]         q_reg;
    logic signed [CW-1:0]  px_reg;
    pwd_pkg::point_t       res_reg;
    pwd_pkg::point_t       out_reg;
    logic                  out_valid_reg;

    logic [LW-1:0]          mul_a;
    logic [BW-1:0]          mul_b;
    logic [PW-1:0]          prod;

    logic                   accept;
    logic signed [CW:0]     dx, dy;
    logic [LW+2:0]          rr, trial;
    logic [HW-1:0]          reach_sum;
    logic [TW-1:0]          rem;
    logic [LW:0]            div_d;
    logic                   div_bit;
    logic [QW-1:0]          q_eff;
    logic [LW-1:0]          off;
    logic signed [CW+1:0]   coord_sum;
    logic                   neg_sel;
    logic signed [CW-1:0]   prev_sel;

    pwd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pwd_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign dx = {in_data.vertex_x[CW-1], in_data.vertex_x} - {prev_x_reg[CW-1], prev_x_reg};
    assign dy = {in_data.vertex_y[CW-1], in_data.vertex_y} - {prev_y_reg[CW-1], prev_y_reg};

    // one root digit per cycle
    assign rr    = {rrem_reg[LW:0], sq_reg[SW-1:SW-2]};
    assign trial = {1'b0, root_reg, 2'b01};

    assign reach_sum = HW'(walked_reg) + HW'(root_reg);
    assign rem       = (cfg.target_distance > walked_reg) ?
                       cfg.target_distance - walked_reg : '0;

    assign div_bit = (divr_reg >= {1'b0, root_reg});
    assign div_d   = div_bit ? divr_reg - {1'b0, root_reg} : divr_reg;
    assign q_eff   = (root_reg == '0) ? '0 : q_reg;

    always_comb
    begin
        mul_a = ax_reg;
        mul_b = BW'(q_eff);
        unique case (state_reg)
            S_SQX:   begin mul_a = ax_reg; mul_b = BW'(ax_reg); end
            S_SQY:   begin mul_a = ay_reg; mul_b = BW'(ay_reg); end
            S_MX:    begin mul_a = ax_reg; mul_b = BW'(q_eff);  end
            S_MY:    begin mul_a = ay_reg; mul_b = BW'(q_eff);  end
            default: ;
        endcase
    end

    // offset truncated toward zero, then added to the segment start
    assign off       = prod[FW+LW-1:FW];
    assign neg_sel   = (state_reg == S_MY) ? negx_reg : negy_reg;
    assign prev_sel  = (state_reg == S_MY) ? prev_x_reg : prev_y_reg;
    assign coord_sum = {{2{prev_sel[CW-1]}}, prev_sel}
                       + (neg_sel ? -$signed({1'b0, off}) : $signed({1'b0, off}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            walked_reg    <= '0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // while loading the output, that state owns the valid flag
            if (out_valid_reg && out_ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        x_reg    <= in_data.vertex_x;
                        y_reg    <= in_data.vertex_y;
                        last_reg <= in_data.last_vertex;
                        ax_reg   <= dx[CW] ? LW'(-dx) : LW'(dx);
                        ay_reg   <= dy[CW] ? LW'(-dy) : LW'(dy);
                        negx_reg <= dx[CW];
                        negy_reg <= dy[CW];
                        res_reg  <= '{point_x: '0, point_y: '0, point_index: '0,
                                      status: pwd_pkg::ST_INVALID};
                        if (cfg.out_capacity <= pwd_pkg::CAP_W'(1))
                        begin
                            if (in_data.last_vertex)
                            begin
                                prev_x_reg <= '0;
                                prev_y_reg <= '0;
                                walked_reg <= '0;
                                count_reg  <= '0;
                                found_reg  <= 1'b0;
                                state_reg  <= S_OUT;
                            end
                        end
                        else if (found_reg)
                        begin
                            if (in_data.last_vertex)
                            begin
                                prev_x_reg <= '0;
                                prev_y_reg <= '0;
                                walked_reg <= '0;
                                count_reg  <= '0;
                                found_reg  <= 1'b0;
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            if (in_data.last_vertex)
                            begin
                                prev_x_reg <= '0;
                                prev_y_reg <= '0;
                                walked_reg <= '0;
                                state_reg  <= S_OUT;
                            end
                            else
                            begin
                                prev_x_reg <= in_data.vertex_x;
                                prev_y_reg <= in_data.vertex_y;
                                count_reg  <= IW'(1);
                            end
                        end
                        else
                        begin
                            state_reg <= S_SQX;
                        end
                    end
                end
                S_SQX:
                begin
                    state_reg <= S_SQY;
                end
                S_SQY:
                begin
                    sq_reg    <= SW'(prod);
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    sq_reg    <= sq_reg + SW'(prod);
                    rrem_reg  <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= NW'(LW - 1);
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (rr >= trial)
                    begin
                        rrem_reg <= rr - trial;
                        root_reg <= {root_reg[LW-2:0], 1'b1};
                    end
                    else
                    begin
                        rrem_reg <= rr;
                        root_reg <= {root_reg[LW-2:0], 1'b0};
                    end
                    sq_reg  <= {sq_reg[SW-3:0], 2'b00};
                    cnt_reg <= cnt_reg - NW'(1);
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    if (reach_sum >= HW'(cfg.target_distance))
                    begin
                        divr_reg  <= (LW+1)'(rem);
                        q_reg     <= '0;
                        cnt_reg   <= NW'(QW - 1);
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        res_reg <= '{point_x: prev_x_reg, point_y: prev_y_reg,
                                     point_index: count_reg,
                                     status: last_reg ? pwd_pkg::ST_SHORT : pwd_pkg::ST_PASS};
                        if (last_reg)
                        begin
                            prev_x_reg <= '0;
                            prev_y_reg <= '0;
                            walked_reg <= '0;
                            count_reg  <= '0;
                        end
                        else
                        begin
                            walked_reg <= reach_sum[TW-1:0];
                            prev_x_reg <= x_reg;
                            prev_y_reg <= y_reg;
                            if (count_reg != '1)
                            begin
                                count_reg <= count_reg + IW'(1);
                            end
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_DIV:
                begin
                    divr_reg <= {div_d[LW-1:0], 1'b0};
                    q_reg    <= {q_reg[QW-2:0], div_bit};
                    cnt_reg  <= cnt_reg - NW'(1);
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_MX;
                    end
                end
                S_MX:
                begin
                    state_reg <= S_MY;
                end
                S_MY:
                begin
                    px_reg    <= coord_sum[CW-1:0];
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    res_reg <= '{point_x: px_reg, point_y: coord_sum[CW-1:0],
                                 point_index: count_reg + IW'(1),
                                 status: pwd_pkg::ST_TARGET};
                    if (last_reg)
                    begin
                        prev_x_reg <= '0;
                        prev_y_reg <= '0;
                        walked_reg <= '0;
                        count_reg  <= '0;
                    end
                    else
                    begin
                        found_reg <= 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // fraction never exceeds one since the remaining distance fits the segment
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MX) |-> (q_eff <= QW'(1 << FW)))
        else $error("ratio above one");

    assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (count_reg != '0))
        else $error("target found on empty path");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQX) |-> (count_reg != '0) && !found_reg)
        else $error("segment started without a previous vertex");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !out_ready) |=> (state_reg == S_OUT))
        else $error("result dropped while output stalled");

endmodule
